/* hdl/fgtc_pkg.sv */
// Package with the widths, codes and gear table of the fan gear thermal controller.
`default_nettype none

package fgtc_pkg;

    localparam int TEMP_W      = 9;
    localparam int THR_W       = 11;
    localparam int GEAR_W      = 3;
    localparam int PWM_W       = 10;
    localparam int POWER_W     = 16;
    localparam int COUNT_W     = 4;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_FORCE   = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_UNUSED  = 2'd3
    } func_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_UP_TEMP_BASE    = 3'd0,
        REG_GEAR_STEP       = 3'd1,
        REG_HYSTERESIS      = 3'd2,
        REG_POWER_ON_LEVEL  = 3'd3,
        REG_POWER_OFF_LEVEL = 3'd4,
        REG_SAMPLE_PERIOD   = 3'd5,
        REG_PWM_LIMIT       = 3'd6,
        REG_SPARE           = 3'd7
    } cfg_reg_t;

    localparam logic [GEAR_W-1:0] GEAR_OFF  = 3'd0;
    localparam logic [GEAR_W-1:0] GEAR_ONE  = 3'd1;
    localparam logic [GEAR_W-1:0] GEAR_KICK = 3'd2;
    localparam logic [GEAR_W-1:0] GEAR_FULL = 3'd4;

    localparam logic signed [TEMP_W-1:0] RELEASE_TEMP = 9'sd25;
    localparam logic [TEMP_W-1:0]        FLOOR_MAX    = 9'd255;

    function automatic logic [PWM_W-1:0] gear_pwm(input logic [GEAR_W-1:0] g);
        logic [PWM_W-1:0] p;
        case (g)
            3'd1:    p = 10'd200;
            3'd2:    p = 10'd500;
            3'd3:    p = 10'd800;
            3'd4:    p = 10'd1000;
            default: p = 10'd0;
        endcase
        return p;
    endfunction

    // Up threshold of a gear, given the gear number minus one.
    function automatic logic signed [THR_W-1:0] up_thr(input logic [7:0] base,
                                                        input logic [4:0] step,
                                                        input logic [1:0] km1);
        logic [THR_W-1:0] sum;
        sum = {3'b000, base} + (THR_W'(km1) * THR_W'(step));
        return $signed(sum);
    endfunction

endpackage

`default_nettype wire

/* hdl/fan_gear_thermal_controller.sv */
// Top level of the fan gear thermal controller: input stage, gear ladder and result stage.
// A transaction is accepted into the input register and its result is registered in the result
// register, which drives m_tvalid. Throughput: one transaction per cycle while m_tready is high;
// the gear ladder is a single pass of compare logic between the input and result registers.
// Reset (aresetn low, synchronous) empties both stages, turns the fan off, zeroes the held
// temperature, sample count and flags, and loads the register defaults.
`default_nettype none

module fan_gear_thermal_controller
    import fgtc_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // s_tdata from bit 0: system_active[0], max_temp[9:1], out_power[25:10],
    // charger_active[26], zeros[31:27]
    input  wire [S_TDATA_W-1:0]    s_tdata,
    // s_tuser: func[1:0]
    input  wire [1:0]              s_tuser,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // m_tdata from bit 0: gear[2:0], pwm_level[12:3], pwm_enable[13], zeros[15:14]
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire [CFG_DATA_W-1:0]   cfg_data
);

    logic [7:0]         up_temp_base_reg;
    logic [4:0]         gear_step_reg;
    logic [3:0]         hysteresis_reg;
    logic [POWER_W-1:0] power_on_level_reg;
    logic [POWER_W-1:0] power_off_level_reg;
    logic [COUNT_W-1:0] sample_period_reg;
    logic [PWM_W-1:0]   pwm_limit_reg;

    logic                     in_valid_reg;
    func_t                    in_func_reg;
    logic                     in_active_reg;
    logic signed [TEMP_W-1:0] in_temp_reg;
    logic [POWER_W-1:0]       in_power_reg;
    logic                     in_charger_reg;

    logic                     out_valid_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;

    logic signed [TEMP_W-1:0] held_temp_reg, held_temp_next;
    logic [COUNT_W-1:0]       sample_count_reg, sample_count_next;
    logic                     power_flag_reg, power_flag_next;
    logic [GEAR_W-1:0]        gear_reg, gear_next;
    logic                     kick_done_reg, kick_done_next;
    logic [M_TDATA_W-1:0]     out_data_next;

    logic                     advance;
    logic [8:0]               base_plus_one;
    logic signed [TEMP_W-1:0] floor_temp;
    logic [COUNT_W-1:0]       count_inc;
    logic signed [TEMP_W-1:0] t;
    logic signed [THR_W-1:0]  t_ext;
    logic signed [THR_W-1:0]  thr_lo;
    logic signed [THR_W-1:0]  thr_hi;
    logic [GEAR_W-1:0]        ladder_gear;
    logic [PWM_W-1:0]         pwm_value;
    logic [PWM_W-1:0]         pwm_level;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    assign base_plus_one = {1'b0, up_temp_base_reg} + 9'd1;
    assign floor_temp    = $signed((base_plus_one > FLOOR_MAX) ? FLOOR_MAX : base_plus_one);
    assign count_inc     = sample_count_reg + COUNT_W'(1);

    always_comb begin
        held_temp_next    = held_temp_reg;
        sample_count_next = sample_count_reg;
        power_flag_next   = power_flag_reg;
        gear_next         = gear_reg;
        kick_done_next    = kick_done_reg;
        t                 = held_temp_reg;
        t_ext             = THR_W'(t);
        thr_lo            = up_thr(up_temp_base_reg, gear_step_reg, 2'(gear_reg - GEAR_ONE));
        thr_hi            = up_thr(up_temp_base_reg, gear_step_reg, 2'(gear_reg));
        ladder_gear       = gear_reg;
        case (in_func_reg)
            FUNC_TICK: begin
                if (!in_active_reg) begin
                    gear_next      = GEAR_OFF;
                    kick_done_next = 1'b0;
                end else begin
                    sample_count_next = count_inc;
                    if (count_inc >= sample_period_reg) begin
                        held_temp_next    = in_temp_reg;
                        sample_count_next = '0;
                    end
                    if (in_power_reg > power_on_level_reg) begin
                        power_flag_next = 1'b1;
                    end
                    if (in_power_reg < power_off_level_reg) begin
                        power_flag_next = 1'b0;
                    end
                    if (held_temp_next < floor_temp && (in_charger_reg || power_flag_next)) begin
                        held_temp_next = floor_temp;
                    end
                    t     = held_temp_next;
                    t_ext = THR_W'(t);
                    if (gear_reg == GEAR_OFF) begin
                        if (t_ext > $signed({3'b000, up_temp_base_reg})) begin
                            ladder_gear = GEAR_ONE;
                        end
                    end else if (gear_reg < GEAR_FULL) begin
                        if (t_ext < thr_lo - $signed({7'b0, hysteresis_reg})) begin
                            ladder_gear = gear_reg - GEAR_ONE;
                        end else if (t_ext > thr_hi) begin
                            ladder_gear = gear_reg + GEAR_ONE;
                        end
                    end else begin
                        if (t_ext < thr_lo - $signed({7'b0, hysteresis_reg})) begin
                            ladder_gear = GEAR_FULL - GEAR_ONE;
                        end
                    end
                    gear_next = ladder_gear;
                    if (ladder_gear == GEAR_OFF) begin
                        kick_done_next = 1'b0;
                    end
                    if (ladder_gear == GEAR_ONE && !kick_done_next) begin
                        kick_done_next = 1'b1;
                        gear_next      = GEAR_KICK;
                    end
                end
            end
            FUNC_FORCE: begin
                if (held_temp_reg < floor_temp) begin
                    held_temp_next    = floor_temp;
                    sample_count_next = '0;
                end
            end
            FUNC_RELEASE: begin
                held_temp_next = RELEASE_TEMP;
            end
            default: begin
            end
        endcase
    end

    assign pwm_value = gear_pwm(gear_next);
    assign pwm_level = (pwm_value < pwm_limit_reg) ? pwm_value : pwm_limit_reg;
    assign out_data_next = {2'b00, (pwm_level != '0), pwm_level, gear_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            held_temp_reg       <= '0;
            sample_count_reg    <= '0;
            power_flag_reg      <= 1'b0;
            gear_reg            <= GEAR_OFF;
            kick_done_reg       <= 1'b0;
            up_temp_base_reg    <= 8'd40;
            gear_step_reg       <= 5'd4;
            hysteresis_reg      <= 4'd2;
            power_on_level_reg  <= 16'd100;
            power_off_level_reg <= 16'd50;
            sample_period_reg   <= 4'd3;
            pwm_limit_reg       <= 10'd1000;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                held_temp_reg    <= held_temp_next;
                sample_count_reg <= sample_count_next;
                power_flag_reg   <= power_flag_next;
                gear_reg         <= gear_next;
                kick_done_reg    <= kick_done_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_UP_TEMP_BASE:    up_temp_base_reg    <= cfg_data[7:0];
                    REG_GEAR_STEP:       gear_step_reg       <= cfg_data[4:0];
                    REG_HYSTERESIS:      hysteresis_reg      <= cfg_data[3:0];
                    REG_POWER_ON_LEVEL:  power_on_level_reg  <= cfg_data;
                    REG_POWER_OFF_LEVEL: power_off_level_reg <= cfg_data;
                    REG_SAMPLE_PERIOD:   sample_period_reg   <= cfg_data[3:0];
                    REG_PWM_LIMIT:       pwm_limit_reg       <= cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset; they are qualified by the valid flags.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg    <= func_t'(s_tuser);
            in_active_reg  <= s_tdata[0];
            in_temp_reg    <= $signed(s_tdata[9:1]);
            in_power_reg   <= s_tdata[25:10];
            in_charger_reg <= s_tdata[26];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
